// ===== rtl/small_key_value_table_assert.svh =====
// assertion macros of the key/value table, used by the datapath module
`ifndef SMALL_KEY_VALUE_TABLE_ASSERT_SVH
`define SMALL_KEY_VALUE_TABLE_ASSERT_SVH

// clocked assertion, switched off while reset is asserted
`define SKVT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SKVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/skvt_pkg.sv =====
// shared types and constants of the key/value table
package skvt_pkg;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OP_W   = 2;

  // request operation codes, code 3 changes no slot and returns ok low
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ERASE = 2'd2
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic rd_en;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_addr;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/skvt_ram.sv =====
// generic single write port RAM with registered read
module skvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/skvt_ctrl.sv =====
// request sequencer of the key/value table
module skvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  skvt_pkg::status_t status_i,
  output skvt_pkg::cmd_t    cmd_o
);

  skvt_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skvt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skvt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = skvt_pkg::ST_SCAN;
      end
      skvt_pkg::ST_SCAN: begin
        if (status_i.last_addr) state_d = skvt_pkg::ST_LAST;
      end
      skvt_pkg::ST_LAST: begin
        state_d = skvt_pkg::ST_COMMIT;
      end
      skvt_pkg::ST_COMMIT: begin
        if (status_i.out_free) state_d = skvt_pkg::ST_IDLE;
      end
      default: state_d = skvt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      skvt_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.start  = in_valid_i;
      end
      skvt_pkg::ST_SCAN: begin
        cmd_o.rd_en  = 1'b1;
      end
      skvt_pkg::ST_LAST: begin
        cmd_o        = '0;
      end
      skvt_pkg::ST_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o        = '0;
      end
    endcase
  end

endmodule

// ===== rtl/skvt_datapath.sv =====
// slot store, key compare and result register of the key/value table
`include "small_key_value_table_assert.svh"

module skvt_datapath #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [skvt_pkg::OP_W-1:0]           operation_i,
  input  logic [skvt_pkg::HALF_W-1:0]         user_key_i,
  input  logic [skvt_pkg::HALF_W-1:0]         item_key_i,
  input  logic signed [skvt_pkg::VAL_W-1:0]   write_value_i,
  input  skvt_pkg::cmd_t                      cmd_i,
  output skvt_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic signed [skvt_pkg::VAL_W-1:0]   read_value_o
);

  localparam int unsigned ROW_W = skvt_pkg::KEY_W + skvt_pkg::VAL_W;

  // request registers
  logic [skvt_pkg::OP_W-1:0]  op_q;
  logic [skvt_pkg::KEY_W-1:0] key_q;
  logic [skvt_pkg::VAL_W-1:0] wval_q;

  // scan control
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  // slot valid bits
  logic [ENTRIES-1:0] valid_q, valid_d;

  // scan results
  logic                       hit_found_q, hit_found_d;
  logic [IDX_W-1:0]           hit_idx_q;
  logic [skvt_pkg::VAL_W-1:0] hit_val_q;
  logic                       free_found_q, free_found_d;
  logic [IDX_W-1:0]           free_idx_q;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic                       ok_q, ok_d;
  logic [skvt_pkg::VAL_W-1:0] rd_val_q, rd_val_d;

  // ram signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  logic cmp_valid;
  logic match;
  logic is_write;
  logic is_erase;
  logic out_free;

  skvt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign is_write = (op_q == skvt_pkg::OP_WRITE);
  assign is_erase = (op_q == skvt_pkg::OP_ERASE);

  // compare the slot read last cycle against the request key
  assign cmp_valid = cmp_vld_q & valid_q[cmp_idx_q];
  assign match     = cmp_valid &
                     (ram_rdata[ROW_W-1 -: skvt_pkg::KEY_W] == key_q);

  assign out_free = !out_valid_q || !out_stall_i;

  // scan address and hit or free tracking
  always_comb begin
    rd_addr_d    = rd_addr_q;
    hit_found_d  = hit_found_q;
    free_found_d = free_found_q;
    if (cmd_i.start) begin
      rd_addr_d    = '0;
      hit_found_d  = 1'b0;
      free_found_d = 1'b0;
    end else begin
      if (cmd_i.rd_en) rd_addr_d = rd_addr_q + IDX_W'(1);
      if (match) hit_found_d = 1'b1;
      if (cmp_vld_q && !valid_q[cmp_idx_q]) free_found_d = 1'b1;
    end
  end

  // slot store write at commit: update a hit, else fill the free slot
  always_comb begin
    ram_we    = cmd_i.commit && is_write && (hit_found_q || free_found_q);
    ram_waddr = hit_found_q ? hit_idx_q : free_idx_q;
    ram_wdata = {key_q, wval_q};
  end

  // valid bits: erase clears matches during the scan, a new write sets one
  always_comb begin
    valid_d = valid_q;
    if (match && is_erase) begin
      valid_d[cmp_idx_q] = 1'b0;
    end
    if (cmd_i.commit && is_write && !hit_found_q && free_found_q) begin
      valid_d[free_idx_q] = 1'b1;
    end
  end

  // result of the transaction
  always_comb begin
    ok_d     = 1'b0;
    rd_val_d = '0;
    case (op_q)
      skvt_pkg::OP_WRITE: begin
        ok_d = hit_found_q || free_found_q;
      end
      skvt_pkg::OP_READ: begin
        ok_d     = hit_found_q;
        rd_val_d = hit_found_q ? hit_val_q : '0;
      end
      skvt_pkg::OP_ERASE: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign out_valid_d = cmd_i.commit || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q    <= '0;
      cmp_vld_q    <= 1'b0;
      valid_q      <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_addr_q    <= rd_addr_d;
      cmp_vld_q    <= cmd_i.rd_en;
      valid_q      <= valid_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= operation_i;
      key_q  <= {user_key_i, item_key_i};
      wval_q <= write_value_i;
    end
    if (cmd_i.rd_en) begin
      cmp_idx_q <= rd_addr_q;
    end
    if (match && !hit_found_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_val_q <= ram_rdata[skvt_pkg::VAL_W-1:0];
    end
    if (cmp_vld_q && !valid_q[cmp_idx_q]) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      ok_q     <= ok_d;
      rd_val_q <= rd_val_d;
    end
  end

  assign status_o.last_addr = (rd_addr_q == IDX_W'(ENTRIES - 1));
  assign status_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign read_value_o = rd_val_q;

  // a new slot is only ever filled where the slot is free
  `SKVT_ASSERT(a_fill_free_slot, clk_i, rst_ni, (ram_we && !hit_found_q) |-> !valid_q[free_idx_q], "fill targets a valid slot")
  // no compare may be pending when a new transaction starts
  `SKVT_ASSERT(a_start_clean, clk_i, rst_ni, cmd_i.start |-> !cmp_vld_q, "compare pending at start")
  // a result only appears after a commit
  `SKVT_ASSERT(a_result_from_commit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.commit), "result without commit")
  // the first hit is kept until the next transaction
  `SKVT_ASSERT(a_hit_sticky, clk_i, rst_ni, (hit_found_q && !cmd_i.start) |=> hit_found_q, "hit lost mid transaction")

endmodule

// ===== rtl/small_key_value_table.sv =====
// top level of the fully associative key/value table
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: operation,
//   user_key, item_key and write_value. The full key is user_key in the
//   upper half and item_key in the lower half. Output channel
//   (out_valid_o / out_stall_i) returns one result per request: ok and
//   read_value. A transaction moves when valid is high and stall is low.
//   A new request is taken only once the last one has committed; the pace
//   is set by the single read port of the slot RAM, which the scan walks
//   one slot per cycle, then a step to finish the last compare and a step
//   to write back and load the result register.
//   The result register lets the block take the next request while a
//   result waits; if the receiver stalls, the result holds and the next
//   request stops at its commit step until the register frees.
//   Reset clears every slot valid bit at once, so the table is empty and
//   ready as soon as reset is released; key and value storage is not
//   cleared.
module small_key_value_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [skvt_pkg::OP_W-1:0]         operation_i,
  input  logic [skvt_pkg::HALF_W-1:0]       user_key_i,
  input  logic [skvt_pkg::HALF_W-1:0]       item_key_i,
  input  logic signed [skvt_pkg::VAL_W-1:0] write_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [skvt_pkg::VAL_W-1:0] read_value_o
);

  skvt_pkg::cmd_t    cmd;
  skvt_pkg::status_t status;

  // sequencer
  skvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // slot store and result path
  skvt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .user_key_i    (user_key_i),
    .item_key_i    (item_key_i),
    .write_value_i (write_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .read_value_o  (read_value_o)
  );

endmodule
